@@ rtl/dud_pkg.sv @@
// Package for the delta unit decoder: value width, phase codes,
// decoder state and result item types. No dependencies.
package dud_pkg;

  localparam int VALUE_BITS = 32;   // width of accumulated varint values
  localparam int OUT_W      = 32;   // width of run_length / base_offset
  localparam int GROUP_BITS = 7;    // value bits per varint byte
  localparam int HEAD_BITS  = 6;    // length field in the head byte
  localparam int POS_W      = 6;    // group bit position, saturates at 63
  localparam int WIDE_W     = VALUE_BITS + GROUP_BITS;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_LEN  = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic                    copy_flag;
    logic [HEAD_BITS-1:0]    head_length;
    logic [VALUE_BITS-1:0]   accumulator;
    logic [POS_W-1:0]        bit_position;
    logic [VALUE_BITS-1:0]   held_length;
    logic                    overflow_seen;
  } dec_state_t;

  typedef struct packed {
    logic              is_copy;
    logic [OUT_W-1:0]  run_length;
    logic [OUT_W-1:0]  base_offset;
    logic              overflow;
  } dec_result_t;

endpackage

@@ rtl/dud_step.sv @@
// Per-byte next-state and result logic of the delta unit decoder.
// Depends on dud_pkg.
module dud_step
  import dud_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  byte_in,
  output dec_state_t  nxt,
  output logic        res_valid,
  output dec_result_t res
);

  logic [GROUP_BITS-1:0] grp;
  logic [WIDE_W-1:0]     grp_wide;
  logic                  grp_ovf;
  logic [VALUE_BITS-1:0] acc_grp;
  logic [POS_W:0]        pos_sum;
  logic [POS_W-1:0]      pos_next;
  logic [VALUE_BITS-1:0] len;
  logic                  len_ovf;
  logic                  ovf_grp;
  logic                  ovf_len;

  assign grp = byte_in[7:1];

  always_comb begin
    grp_wide = '0;
    if ({1'b0, cur.bit_position} < (POS_W+1)'(VALUE_BITS)) begin
      grp_wide = WIDE_W'(grp) << cur.bit_position;
      grp_ovf  = |grp_wide[WIDE_W-1:VALUE_BITS];
      acc_grp  = cur.accumulator | grp_wide[VALUE_BITS-1:0];
    end else begin
      grp_ovf  = (grp != '0);
      acc_grp  = cur.accumulator;
    end
  end

  assign pos_sum  = {1'b0, cur.bit_position} + (POS_W+1)'(GROUP_BITS);
  assign pos_next = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];

  assign len     = {acc_grp[VALUE_BITS-2:0], 1'b0} | VALUE_BITS'(cur.head_length);
  assign len_ovf = acc_grp[VALUE_BITS-1];
  assign ovf_grp = cur.overflow_seen | grp_ovf;
  assign ovf_len = ovf_grp | len_ovf;

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    unique case (cur.phase)
      PH_LEN, PH_OFF: begin
        nxt.accumulator   = acc_grp;
        nxt.bit_position  = pos_next;
        nxt.overflow_seen = ovf_grp;
        if (!byte_in[0]) begin
          if (cur.phase == PH_LEN) begin
            nxt.overflow_seen = ovf_len;
            if (cur.copy_flag) begin
              nxt.held_length  = len;
              nxt.phase        = PH_OFF;
              nxt.accumulator  = '0;
              nxt.bit_position = '0;
            end else begin
              nxt.phase      = PH_HEAD;
              res_valid      = 1'b1;
              res.is_copy    = 1'b0;
              res.run_length = OUT_W'(len);
              res.overflow   = ovf_len;
            end
          end else begin
            nxt.phase       = PH_HEAD;
            res_valid       = 1'b1;
            res.is_copy     = 1'b1;
            res.run_length  = OUT_W'(cur.held_length);
            res.base_offset = OUT_W'(acc_grp);
            res.overflow    = ovf_grp;
          end
        end
      end
      default: begin
        // head byte; the unused phase code also lands here
        nxt.copy_flag     = byte_in[0];
        nxt.head_length   = byte_in[7:2];
        nxt.overflow_seen = 1'b0;
        nxt.held_length   = VALUE_BITS'(byte_in[7:2]);
        nxt.accumulator   = '0;
        nxt.bit_position  = '0;
        if (byte_in[1]) begin
          nxt.phase = PH_LEN;
        end else if (byte_in[0]) begin
          nxt.phase = PH_OFF;
        end else begin
          nxt.phase      = PH_HEAD;
          res_valid      = 1'b1;
          res.run_length = OUT_W'(byte_in[7:2]);
        end
      end
    endcase
  end

endmodule

@@ rtl/delta_unit_decoder_top.sv @@
// Top level of the delta unit decoder: decoder state register and a
// two-entry result buffer. Depends on dud_pkg and dud_step.
//
// The block takes one instruction-stream byte per clock and registers one
// copy/insert command per completed unit. Each byte updates the registered
// decoder state, so the sustained rate is one byte per clock unless output
// stalls fill the result buffer. Results pass through an output register
// backed by a skid entry; input is held off only while both are full.
module delta_unit_decoder_top
  import dud_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          byte_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                is_copy,
  output logic [OUT_W-1:0]    run_length,
  output logic [OUT_W-1:0]    base_offset,
  output logic                overflow
);

  dec_state_t  state;
  dec_state_t  state_next;
  logic        res_valid;
  dec_result_t res;
  dec_result_t main_res;
  dec_result_t skid_res;
  logic        skid_valid;
  logic        in_fire;
  logic        out_fire;

  dud_step u_step (
    .cur       (state),
    .byte_in   (byte_in),
    .nxt       (state_next),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        state <= state_next;
      end
      if (skid_valid) begin
        if (out_fire) begin
          main_res   <= skid_res;
          skid_valid <= 1'b0;
        end
      end else if (in_fire && res_valid) begin
        if (!out_valid || out_fire) begin
          main_res  <= res;
          out_valid <= 1'b1;
        end else begin
          skid_res   <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign is_copy     = main_res.is_copy;
  assign run_length  = main_res.run_length;
  assign base_offset = main_res.base_offset;
  assign overflow    = main_res.overflow;

endmodule

@@ tb/dud_cmd_checker.sv @@
// Command checker for the delta unit decoder: decodes the accepted byte stream
// itself and compares each emitted command with the oldest one it predicted.
// Depends on dud_pkg.
module dud_cmd_checker
  import dud_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       byte_in,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             is_copy,
  input  logic [OUT_W-1:0] run_length,
  input  logic [OUT_W-1:0] base_offset,
  input  logic             overflow,
  output int               cmds_due,
  output int               fail_count
);

  localparam logic [63:0] VMASK = (VALUE_BITS >= 64) ? {64{1'b1}} :
                                  ((64'd1 << VALUE_BITS) - 64'd1);

  // decoder state as predicted
  phase_t      ph;
  logic        cflag;
  logic [5:0]  hfield;
  logic [63:0] acc;
  int          gpos;
  logic [63:0] held;
  logic        lost_bits;

  dec_result_t expected_cmds [$];
  int          mismatches = 0;
  logic        cmd_done;
  dec_result_t cmd_new, cmd_want;

  function automatic dec_result_t pack_cmd(input logic cp, input logic [63:0] len,
                                           input logic [63:0] off, input logic ovf);
    dec_result_t c;
    c.is_copy     = cp;
    c.run_length  = len[OUT_W-1:0];
    c.base_offset = cp ? off[OUT_W-1:0] : '0;
    c.overflow    = ovf;
    return c;
  endfunction

  task automatic decode_byte(input logic [7:0] b, output logic done,
                             output dec_result_t cmd);
    logic [63:0] v, sh, len;
    done = 1'b0;
    cmd  = '0;
    if (ph == PH_LEN || ph == PH_OFF) begin
      v  = {57'd0, b[7:1]};
      sh = v << gpos;
      if ((gpos > 57 && (v >> (64 - gpos)) != 0) || (sh & ~VMASK) != 0)
        lost_bits = 1'b1;
      acc  = (acc | sh) & VMASK;
      gpos = (gpos + 7 > 63) ? 63 : gpos + 7;
      if (!b[0]) begin
        if (ph == PH_LEN) begin
          // length varint is shifted left by one and ORed with the head field
          if (((acc << 1) & ~VMASK) != 0 || acc[63])
            lost_bits = 1'b1;
          len = ((acc << 1) | {58'd0, hfield}) & VMASK;
          if (cflag) begin
            held = len;
            ph   = PH_OFF;
            acc  = '0;
            gpos = 0;
          end else begin
            done = 1'b1;
            cmd  = pack_cmd(1'b0, len, '0, lost_bits);
            ph   = PH_HEAD;
          end
        end else begin
          done = 1'b1;
          cmd  = pack_cmd(1'b1, held, acc, lost_bits);
          ph   = PH_HEAD;
        end
      end
    end else begin
      cflag     = b[0];
      hfield    = b[7:2];
      lost_bits = 1'b0;
      held      = {58'd0, b[7:2]};
      acc       = '0;
      gpos      = 0;
      if (b[1]) begin
        ph = PH_LEN;
      end else if (b[0]) begin
        ph = PH_OFF;
      end else begin
        done = 1'b1;
        cmd  = pack_cmd(1'b0, held, '0, 1'b0);
        ph   = PH_HEAD;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ph        = PH_HEAD;
      cflag     = 1'b0;
      hfield    = '0;
      acc       = '0;
      gpos      = 0;
      held      = '0;
      lost_bits = 1'b0;
      expected_cmds.delete();
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(byte_in, cmd_done, cmd_new);
        if (cmd_done)
          expected_cmds.push_back(cmd_new);
      end
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected cmd: copy=%0b len=%08h off=%08h ovf=%0b",
                     is_copy, run_length, base_offset, overflow);
        end else begin
          cmd_want = expected_cmds.pop_front();
          if (is_copy !== cmd_want.is_copy || run_length !== cmd_want.run_length ||
              base_offset !== cmd_want.base_offset || overflow !== cmd_want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cmd mismatch: exp copy=%0b len=%08h off=%08h ovf=%0b, %s",
                       cmd_want.is_copy, cmd_want.run_length, cmd_want.base_offset,
                       cmd_want.overflow,
                       $sformatf("got copy=%0b len=%08h off=%08h ovf=%0b",
                                 is_copy, run_length, base_offset, overflow));
          end
        end
      end
    end
    cmds_due   <= expected_cmds.size();
    fail_count <= mismatches;
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for delta_unit_decoder_top: drives a byte stream of directed
// and random units with random idling on both sides; checking is done in
// dud_cmd_checker. Depends on dud_pkg, dud_cmd_checker and the decoder RTL.
module tb
  import dud_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STREAM_BYTES   = 520;
  localparam int CALM_AFTER     = 420;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [7:0]       byte_in   = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             is_copy;
  logic [OUT_W-1:0] run_length;
  logic [OUT_W-1:0] base_offset;
  logic             overflow;

  int               cmds_due;
  int               fail_count;
  int               idle_cycles = 0;
  logic [31:0]      cyc = '0;
  int               bytes_sent = 0;
  logic             calm = 1'b0;
  logic             paused = 1'b0;

  // short inserts, max copy offset, length-shift overflow, zero-length copies
  logic [7:0] opening [20] = '{
    8'h00, 8'hFC,
    8'h01, 8'h00,
    8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1E,
    8'h02, 8'h01, 8'h01, 8'h01, 8'h01, 8'h10,
    8'h03, 8'h00, 8'h00
  };

  delta_unit_decoder_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_in     (byte_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_copy     (is_copy),
    .run_length  (run_length),
    .base_offset (base_offset),
    .overflow    (overflow)
  );

  dud_cmd_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_in     (byte_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_copy     (is_copy),
    .run_length  (run_length),
    .base_offset (base_offset),
    .overflow    (overflow),
    .cmds_due    (cmds_due),
    .fail_count  (fail_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 32'd1;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stall bursts, with quiet stretches
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && cyc[7:6] != 2'b01 && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && cyc[8:7] != 2'b10 && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (bytes_sent >= CALM_AFTER)
      calm = 1'b1;
  endtask

  function automatic int pick_groups();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
  endfunction

  task automatic send_varint(input int groups);
    logic [6:0] g;
    for (int i = 0; i < groups; i++) begin
      g = 7'($urandom_range(0, 127));
      send_byte({g, (i != groups - 1)});
    end
  endtask

  task automatic send_unit();
    logic [7:0] head;
    head = 8'($urandom_range(0, 255));
    send_byte(head);
    if (head[1])
      send_varint(pick_groups());
    if (head[0])
      send_varint(pick_groups());
  endtask

  task automatic drain_cmds();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cmds_due != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i])
      send_byte(opening[i]);
    drain_cmds();

    while (bytes_sent < STREAM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        // stray bytes break unit boundaries
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_unit();
      end
      if (!paused && bytes_sent >= STREAM_BYTES / 2) begin
        drain_cmds();
        paused = 1'b1;
      end
    end

    drain_cmds();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
